// ===== rtl/polymetric_step_sequencer_assert.svh =====
// assertion macros used by the step sequencer checker
`ifndef POLYMETRIC_STEP_SEQUENCER_ASSERT_SVH
`define POLYMETRIC_STEP_SEQUENCER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pss check failed");

// consequent must hold in the cycle after the antecedent
`define PSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pss check failed");

`endif

// ===== rtl/pss_pkg.sv =====
// shared constants, types and codes of the polymetric step sequencer
package pss_pkg;

    localparam int LANES = 16;
    localparam int STEPS = 64;

    // payload field widths
    localparam int CMD_W    = 2;
    localparam int LANE_IN_W = 4;
    localparam int SLOT_IN_W = 6;
    localparam int VEL_W    = 7;
    localparam int LEN_IN_W = 8;
    localparam int PAD_W    = 4;
    localparam int IDX_W    = 48;
    localparam int TOTAL_W  = 32;
    localparam int CFG_W    = 5;

    // derived storage widths
    localparam int LANE_W    = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int SLOT_W    = $clog2(STEPS);
    localparam int LEN_W     = $clog2(STEPS + 1);
    localparam int CNT_W     = $clog2(LANES + 1);
    localparam int ADDR_W    = LANE_W + SLOT_W;
    localparam int DIGIT_W   = 8;
    localparam int DIGITS    = IDX_W / DIGIT_W;
    localparam int DIG_CNT_W = $clog2(DIGITS);

    typedef logic [LANE_W-1:0]    lane_idx_t;
    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [LEN_W-1:0]     len_t;
    typedef logic [SLOT_W:0]      mod_t;
    typedef logic [CNT_W-1:0]     lane_cnt_t;
    typedef logic [DIG_CNT_W-1:0] dig_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [VEL_W:0]       entry_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_STEP_WRITE = 2'd0,
        CMD_LANE_WRITE = 2'd1,
        CMD_FIRE       = 2'd2
    } cmd_e;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LANE,
        ST_MOD,
        ST_READ,
        ST_CHECK
    } state_e;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic clr_step;
        logic fire_load;
        logic lane_next;
        logic mod_start;
        logic mod_step;
        logic mem_rd;
        logic take_hit;
        logic flush_last;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic lane_end;
        logic lane_off;
        logic mod_last;
        logic hit;
        logic pend_valid;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/pss_if.sv =====
// channel interfaces: command beats, trigger beats and the lane_count write
interface pss_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [pss_pkg::CMD_W-1:0]    command;
    logic [pss_pkg::LANE_IN_W-1:0] lane;
    logic [pss_pkg::SLOT_IN_W-1:0] step_slot;
    logic                         step_on;
    logic [pss_pkg::VEL_W-1:0]    step_velocity;
    logic [pss_pkg::LEN_IN_W-1:0] lane_length;
    logic [pss_pkg::PAD_W-1:0]    target_pad;
    logic [pss_pkg::IDX_W-1:0]    step_index;

    modport source (
        output valid, command, lane, step_slot, step_on, step_velocity,
               lane_length, target_pad, step_index,
        input  ready
    );
    modport sink (
        input  valid, command, lane, step_slot, step_on, step_velocity,
               lane_length, target_pad, step_index,
        output ready
    );
endinterface

interface pss_trig_if;
    logic                        valid;
    logic                        ready;
    logic [pss_pkg::PAD_W-1:0]   pad;
    logic [pss_pkg::VEL_W-1:0]   velocity;
    logic [pss_pkg::TOTAL_W-1:0] trigger_total;
    logic                        last;

    modport source (
        output valid, pad, velocity, trigger_total, last,
        input  ready
    );
    modport sink (
        input  valid, pad, velocity, trigger_total, last,
        output ready
    );
endinterface

interface pss_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [pss_pkg::CFG_W-1:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

// ===== rtl/pss_ctrl.sv =====
// sequencing state machine of the step sequencer
module pss_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [pss_pkg::CMD_W-1:0] in_command,
    output logic            in_ready,
    input  pss_pkg::sts_t   sts,
    output pss_pkg::ctl_t   ctl
);

    pss_pkg::state_e state_reg;
    pss_pkg::state_e state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pss_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            pss_pkg::ST_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = pss_pkg::ST_IDLE;
                end
            end
            pss_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.accept = 1'b1;
                    if (in_command == pss_pkg::CMD_FIRE)
                    begin
                        ctl.fire_load = 1'b1;
                        state_next    = pss_pkg::ST_LANE;
                    end
                end
            end
            pss_pkg::ST_LANE:
            begin
                if (sts.lane_end)
                begin
                    if (!sts.pend_valid)
                    begin
                        state_next = pss_pkg::ST_IDLE;
                    end
                    else if (sts.out_free)
                    begin
                        ctl.flush_last = 1'b1;
                        state_next     = pss_pkg::ST_IDLE;
                    end
                end
                else if (sts.lane_off)
                begin
                    ctl.lane_next = 1'b1;
                end
                else
                begin
                    ctl.mod_start = 1'b1;
                    state_next    = pss_pkg::ST_MOD;
                end
            end
            pss_pkg::ST_MOD:
            begin
                ctl.mod_step = 1'b1;
                if (sts.mod_last)
                begin
                    state_next = pss_pkg::ST_READ;
                end
            end
            pss_pkg::ST_READ:
            begin
                ctl.mem_rd = 1'b1;
                state_next = pss_pkg::ST_CHECK;
            end
            pss_pkg::ST_CHECK:
            begin
                if (!sts.hit)
                begin
                    ctl.lane_next = 1'b1;
                    state_next    = pss_pkg::ST_LANE;
                end
                else if (!sts.pend_valid || sts.out_free)
                begin
                    ctl.take_hit  = 1'b1;
                    ctl.lane_next = 1'b1;
                    state_next    = pss_pkg::ST_LANE;
                end
            end
            default:
            begin
                state_next = pss_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/pss_datapath.sv =====
// pattern storage, modulo unit, trigger counter and output register
module pss_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pss_pkg::ctl_t                  ctl,
    output pss_pkg::sts_t                  sts,
    input  logic [pss_pkg::CMD_W-1:0]      in_command,
    input  logic [pss_pkg::LANE_IN_W-1:0]  in_lane,
    input  logic [pss_pkg::SLOT_IN_W-1:0]  in_step_slot,
    input  logic                           in_step_on,
    input  logic [pss_pkg::VEL_W-1:0]      in_step_velocity,
    input  logic [pss_pkg::LEN_IN_W-1:0]   in_lane_length,
    input  logic [pss_pkg::PAD_W-1:0]      in_target_pad,
    input  logic [pss_pkg::IDX_W-1:0]      in_step_index,
    input  logic                           cfg_write,
    input  logic [pss_pkg::CFG_W-1:0]      cfg_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [pss_pkg::PAD_W-1:0]      out_pad,
    output logic [pss_pkg::VEL_W-1:0]      out_velocity,
    output logic [pss_pkg::TOTAL_W-1:0]    out_trigger_total,
    output logic                           out_last
);

    // configuration and lane settings
    logic [pss_pkg::CFG_W-1:0] lane_count_reg;
    pss_pkg::len_t             len_reg [pss_pkg::LANES];
    logic [pss_pkg::PAD_W-1:0] pad_reg [pss_pkg::LANES];

    // fire scan
    logic [pss_pkg::IDX_W-1:0] idx_reg;
    logic [pss_pkg::IDX_W-1:0] sh_reg;
    pss_pkg::lane_cnt_t        lanes_reg;
    pss_pkg::lane_cnt_t        lane_ptr_reg;
    pss_pkg::slot_t            rem_reg;
    pss_pkg::slot_t            rem_next;
    pss_pkg::dig_t             dig_reg;
    pss_pkg::addr_t            clr_addr_reg;

    // step memory
    pss_pkg::entry_t           mem [2**pss_pkg::ADDR_W];
    pss_pkg::entry_t           rd_data_reg;
    logic                      mem_we;
    pss_pkg::addr_t            mem_wa;
    pss_pkg::entry_t           mem_wd;
    logic                      step_we;
    logic                      lane_we;

    // triggers
    logic [pss_pkg::TOTAL_W-1:0] count_reg;
    logic                        pend_valid_reg;
    logic [pss_pkg::PAD_W-1:0]   pend_pad_reg;
    logic [pss_pkg::VEL_W-1:0]   pend_vel_reg;
    logic [pss_pkg::TOTAL_W-1:0] pend_total_reg;
    logic                        out_valid_reg;
    logic [pss_pkg::PAD_W-1:0]   out_pad_reg;
    logic [pss_pkg::VEL_W-1:0]   out_vel_reg;
    logic [pss_pkg::TOTAL_W-1:0] out_total_reg;
    logic                        out_last_reg;
    logic                        out_free;

    pss_pkg::lane_idx_t        cur_lane;
    pss_pkg::len_t             cur_len;
    pss_pkg::mod_t             len_ext;
    pss_pkg::mod_t             mod_t_acc [pss_pkg::DIGIT_W+1];
    pss_pkg::mod_t             mod_shift [pss_pkg::DIGIT_W];

    assign cur_lane = pss_pkg::lane_idx_t'(lane_ptr_reg);
    assign cur_len  = len_reg[cur_lane];
    assign len_ext  = pss_pkg::mod_t'(cur_len);
    assign out_free = !out_valid_reg || out_ready;

    assign step_we = ctl.accept && (in_command == pss_pkg::CMD_STEP_WRITE)
                     && (int'(in_lane) < pss_pkg::LANES)
                     && (int'(in_step_slot) < pss_pkg::STEPS);
    assign lane_we = ctl.accept && (in_command == pss_pkg::CMD_LANE_WRITE)
                     && (int'(in_lane) < pss_pkg::LANES);

    // one remainder digit: eight restoring steps on the narrow remainder
    always_comb
    begin
        mod_t_acc[0] = pss_pkg::mod_t'(rem_reg);
        for (int i = 0; i < pss_pkg::DIGIT_W; i++)
        begin
            mod_shift[i] = {mod_t_acc[i][pss_pkg::SLOT_W-1:0],
                            sh_reg[pss_pkg::IDX_W-1-i]};
            if (mod_shift[i] >= len_ext)
            begin
                mod_t_acc[i+1] = mod_shift[i] - len_ext;
            end
            else
            begin
                mod_t_acc[i+1] = mod_shift[i];
            end
        end
        rem_next = mod_t_acc[pss_pkg::DIGIT_W][pss_pkg::SLOT_W-1:0];
    end

    // memory write port: clearing sweep or step write
    always_comb
    begin
        mem_we = ctl.clr_step || step_we;
        if (ctl.clr_step)
        begin
            mem_wa = clr_addr_reg;
            mem_wd = '0;
        end
        else
        begin
            mem_wa = {pss_pkg::lane_idx_t'(in_lane), pss_pkg::slot_t'(in_step_slot)};
            mem_wd = {in_step_on, in_step_velocity};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (ctl.mem_rd)
        begin
            rd_data_reg <= mem[{cur_lane, rem_reg}];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_count_reg <= '0;
            clr_addr_reg   <= '0;
            lane_ptr_reg   <= '0;
            lanes_reg      <= '0;
            dig_reg        <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < pss_pkg::LANES; i++)
            begin
                len_reg[i] <= '0;
                pad_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                lane_count_reg <= cfg_data;
            end
            if (ctl.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + pss_pkg::addr_t'(1);
            end
            if (lane_we)
            begin
                if (int'(in_lane_length) > pss_pkg::STEPS)
                begin
                    len_reg[pss_pkg::lane_idx_t'(in_lane)] <= pss_pkg::len_t'(pss_pkg::STEPS);
                end
                else
                begin
                    len_reg[pss_pkg::lane_idx_t'(in_lane)] <= pss_pkg::len_t'(in_lane_length);
                end
                pad_reg[pss_pkg::lane_idx_t'(in_lane)] <= in_target_pad;
            end
            if (ctl.fire_load)
            begin
                lane_ptr_reg <= '0;
                if (int'(lane_count_reg) > pss_pkg::LANES)
                begin
                    lanes_reg <= pss_pkg::lane_cnt_t'(pss_pkg::LANES);
                end
                else
                begin
                    lanes_reg <= pss_pkg::lane_cnt_t'(lane_count_reg);
                end
            end
            else if (ctl.lane_next)
            begin
                lane_ptr_reg <= lane_ptr_reg + pss_pkg::lane_cnt_t'(1);
            end
            if (ctl.mod_start)
            begin
                dig_reg <= '0;
            end
            else if (ctl.mod_step)
            begin
                dig_reg <= dig_reg + pss_pkg::dig_t'(1);
            end
            if (ctl.take_hit)
            begin
                count_reg      <= count_reg + 1'b1;
                pend_valid_reg <= 1'b1;
            end
            else if (ctl.flush_last)
            begin
                pend_valid_reg <= 1'b0;
            end
            if ((ctl.take_hit && pend_valid_reg) || ctl.flush_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.fire_load)
        begin
            idx_reg <= in_step_index;
        end
        if (ctl.mod_start)
        begin
            sh_reg  <= idx_reg;
            rem_reg <= '0;
        end
        else if (ctl.mod_step)
        begin
            sh_reg  <= sh_reg << pss_pkg::DIGIT_W;
            rem_reg <= rem_next;
        end
        if (ctl.take_hit)
        begin
            pend_pad_reg   <= pad_reg[cur_lane];
            pend_vel_reg   <= rd_data_reg[pss_pkg::VEL_W-1:0];
            pend_total_reg <= count_reg + 1'b1;
        end
        if ((ctl.take_hit && pend_valid_reg) || ctl.flush_last)
        begin
            out_pad_reg   <= pend_pad_reg;
            out_vel_reg   <= pend_vel_reg;
            out_total_reg <= pend_total_reg;
            out_last_reg  <= ctl.flush_last;
        end
    end

    always_comb
    begin
        sts.clr_last   = &clr_addr_reg;
        sts.lane_end   = lane_ptr_reg >= lanes_reg;
        sts.lane_off   = cur_len == '0;
        sts.mod_last   = dig_reg == pss_pkg::dig_t'(pss_pkg::DIGITS - 1);
        sts.hit        = rd_data_reg[pss_pkg::VEL_W];
        sts.pend_valid = pend_valid_reg;
        sts.out_free   = out_free;
    end

    assign out_valid         = out_valid_reg;
    assign out_pad           = out_pad_reg;
    assign out_velocity      = out_vel_reg;
    assign out_trigger_total = out_total_reg;
    assign out_last          = out_last_reg;

endmodule

// ===== rtl/polymetric_step_sequencer.sv =====
// top level of the polymetric drum step sequencer
//
// channels: cmd takes command beats (step write, lane write, fire), trig gives
// one beat per pad trigger in lane order, cfg writes the lane_count register
// (always ready, write it only while the block is idle)
// a step write or lane write is taken in the idle state and gives no beat
// a fire scans lanes 0 .. min(lane_count, 16)-1: a disabled lane is only
// stepped past; an enabled lane goes through a start, the index-mod-length
// digit loop at eight bits a cycle, a memory read and a check; the fire ends
// once the last lane is done and any held trigger is passed on, and cmd is ready again
// the remainder loop over the 48-bit index sets the per-lane cost
// each trigger is held in a pending register until the next one, so that last can
// be marked on the final beat of the fire; cmd may take the next command while
// the final beat still waits on trig; after reset the step memory is cleared
// one entry a cycle over all 1024 entries, with cmd not ready; lane settings,
// counter and lane_count clear at once; when trig is stalled the scan waits at
// the next trigger until the output register frees up, and no beat is dropped
module polymetric_step_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    pss_cmd_if.sink     cmd,
    pss_trig_if.source  trig,
    pss_cfg_if.sink     cfg
);

    pss_pkg::ctl_t ctl;
    pss_pkg::sts_t sts;

    // lane_count write never stalls
    assign cfg.ready = 1'b1;

    pss_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cmd.valid),
        .in_command (cmd.command),
        .in_ready   (cmd.ready),
        .sts        (sts),
        .ctl        (ctl)
    );

    pss_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctl               (ctl),
        .sts               (sts),
        .in_command        (cmd.command),
        .in_lane           (cmd.lane),
        .in_step_slot      (cmd.step_slot),
        .in_step_on        (cmd.step_on),
        .in_step_velocity  (cmd.step_velocity),
        .in_lane_length    (cmd.lane_length),
        .in_target_pad     (cmd.target_pad),
        .in_step_index     (cmd.step_index),
        .cfg_write         (cfg.valid),
        .cfg_data          (cfg.data),
        .out_valid         (trig.valid),
        .out_ready         (trig.ready),
        .out_pad           (trig.pad),
        .out_velocity      (trig.velocity),
        .out_trigger_total (trig.trigger_total),
        .out_last          (trig.last)
    );

endmodule

// ===== rtl/pss_checker.sv =====
// port-level checks of the step sequencer and their bind
`include "polymetric_step_sequencer_assert.svh"

module pss_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cmd_ready,
    input logic                           trig_valid,
    input logic                           trig_ready,
    input logic [pss_pkg::PAD_W-1:0]      trig_pad,
    input logic [pss_pkg::VEL_W-1:0]      trig_velocity,
    input logic [pss_pkg::TOTAL_W-1:0]    trig_trigger_total,
    input logic                           trig_last
);

    logic                        seen_reg;
    logic [pss_pkg::TOTAL_W-1:0] prev_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= 1'b0;
            prev_total_reg <= '0;
        end
        else if (trig_valid && trig_ready)
        begin
            seen_reg       <= 1'b1;
            prev_total_reg <= trig_trigger_total;
        end
    end

    // stalled trigger beat stays offered
    `PSS_ASSERT_NEXT(a_trig_hold, trig_valid && !trig_ready, trig_valid)

    // stalled trigger beat keeps its payload
    `PSS_ASSERT_NEXT(a_trig_stable, trig_valid && !trig_ready, $stable(trig_pad) && $stable(trig_velocity) && $stable(trig_trigger_total) && $stable(trig_last))

    // running total steps by one from beat to beat
    `PSS_ASSERT_NOW(a_total_step, trig_valid && trig_ready && seen_reg, trig_trigger_total == prev_total_reg + 1'b1)

    // no new command while a fire still owes its final beat
    `PSS_ASSERT_NOW(a_fire_closed, trig_valid && !trig_last, !cmd_ready)

endmodule

bind polymetric_step_sequencer pss_checker u_pss_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_ready          (cmd.ready),
    .trig_valid         (trig.valid),
    .trig_ready         (trig.ready),
    .trig_pad           (trig.pad),
    .trig_velocity      (trig.velocity),
    .trig_trigger_total (trig.trigger_total),
    .trig_last          (trig.last)
);
